// File: src/dsrm_pkg.sv
// Shared types and constants for the dynamic sequence range-minimum unit.
// Used by dsrm_cell, dsrm_min_tree and dynamic_sequence_range_min_unit.
`default_nettype none

package dsrm_pkg;

    localparam int IDX_W = 11;
    localparam int VAL_W = 32;
    localparam int KEY_W = VAL_W + 1;

    localparam logic [VAL_W-1:0] SIGN_BIT  = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [VAL_W-1:0] EMPTY_MIN = VAL_W'(32'h4000_0000);

    // Sort key: {empty, value with sign bit flipped}; compares as unsigned.
    typedef logic [KEY_W-1:0] key_t;
    localparam key_t KEY_EMPTY = {KEY_W{1'b1}};

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_ERASE  = 2'd1,
        OP_SET    = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STS_DONE       = 2'd0,
        STS_FULL       = 2'd1,
        STS_ERASE_PAST = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_INSERT,
        CMD_ERASE,
        CMD_SET,
        CMD_QUERY
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [IDX_W-1:0]  pos;      // target position, or query start
        logic [IDX_W-1:0]  end_pos;  // clipped exclusive query end
        logic [VAL_W-1:0]  value;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TREE,
        ST_EMIT
    } state_t;

    function automatic key_t key_min(input key_t a, input key_t b);
        return (a < b) ? a : b;
    endfunction

endpackage

`default_nettype wire

// File: src/dsrm_cell.sv
// One storage cell of the sequence: holds one element, shifts with its
// neighbors on insert/erase, and offers a range-masked key to the min tree.
// Depends on dsrm_pkg.
`default_nettype none

module dsrm_cell #(
    parameter int POS_W = 11,
    parameter int POS   = 0
) (
    input  wire logic                      clk,
    input  wire dsrm_pkg::cmd_t            cmd,
    input  wire logic [dsrm_pkg::VAL_W-1:0] left_val,
    input  wire logic [dsrm_pkg::VAL_W-1:0] right_val,
    output logic      [dsrm_pkg::VAL_W-1:0] val,
    output dsrm_pkg::key_t                 cand
);

    localparam logic [POS_W-1:0] MY_POS = POS_W'(POS);

    logic [dsrm_pkg::VAL_W-1:0] val_reg, val_next;
    dsrm_pkg::key_t             cand_reg, cand_next;
    logic [POS_W-1:0]           pos_ext, end_ext;
    logic                       in_range;

    assign pos_ext = POS_W'(cmd.pos);
    assign end_ext = POS_W'(cmd.end_pos);

    always_comb
    begin
        val_next = val_reg;
        unique case (cmd.kind)
            dsrm_pkg::CMD_INSERT:
            begin
                if (MY_POS > pos_ext)
                    val_next = left_val;
                else if (MY_POS == pos_ext)
                    val_next = cmd.value;
            end
            dsrm_pkg::CMD_ERASE:
            begin
                if (MY_POS >= pos_ext)
                    val_next = right_val;
            end
            dsrm_pkg::CMD_SET:
            begin
                if (MY_POS == pos_ext)
                    val_next = cmd.value;
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    assign in_range  = (MY_POS >= pos_ext) && (MY_POS < end_ext);
    assign cand_next = in_range ? {1'b0, val_reg ^ dsrm_pkg::SIGN_BIT} : dsrm_pkg::KEY_EMPTY;

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        cand_reg <= cand_next;
    end

    assign val  = val_reg;
    assign cand = cand_reg;

endmodule

`default_nettype wire

// File: src/dsrm_min_tree.sv
// Registered binary minimum tree over the cell keys, one level per cycle.
// Depends on dsrm_pkg.
`default_nettype none

module dsrm_min_tree #(
    parameter int LEAVES = 1024
) (
    input  wire logic           clk,
    input  wire dsrm_pkg::key_t leaf [LEAVES],
    output dsrm_pkg::key_t      root
);

    localparam int LVL = $clog2(LEAVES);
    localparam int PAD = 1 << LVL;

    dsrm_pkg::key_t leaf_pad [PAD];
    dsrm_pkg::key_t node_reg [1:PAD-1];

    genvar i, j;

    generate
        for (i = 0; i < PAD; i++)
        begin : g_pad
            if (i < LEAVES)
            begin : g_real
                assign leaf_pad[i] = leaf[i];
            end
            else
            begin : g_fill
                assign leaf_pad[i] = dsrm_pkg::KEY_EMPTY;
            end
        end

        // heap order: node j has children 2j and 2j+1; indexes >= PAD are leaves
        for (j = 1; j < PAD; j++)
        begin : g_node
            dsrm_pkg::key_t lo, hi, node_next;
            if (2 * j >= PAD)
            begin : g_bottom
                assign lo = leaf_pad[2*j-PAD];
                assign hi = leaf_pad[2*j+1-PAD];
            end
            else
            begin : g_inner
                assign lo = node_reg[2*j];
                assign hi = node_reg[2*j+1];
            end
            assign node_next = dsrm_pkg::key_min(lo, hi);
            always_ff @(posedge clk)
            begin
                node_reg[j] <= node_next;
            end
        end
    endgenerate

    assign root = node_reg[1];

endmodule

`default_nettype wire

// File: src/dynamic_sequence_range_min_unit.sv
// Top level of the dynamic sequence range-minimum unit: control, cell row,
// min tree and output register. Depends on dsrm_pkg, dsrm_cell, dsrm_min_tree.
`default_nettype none

// The unit holds an ordered sequence of up to CAPACITY signed 32-bit words in a
// row of cells and takes one operation at a time. Insert and erase shift the
// whole row at once and set writes one cell or appends, all in the execute
// state; the result is then loaded into the output register from the emit
// state, and the next word is taken once the unit is back in idle. A query
// masks every cell against the range and drains the registered min tree of
// log2(CAPACITY) levels in the tree state before the emit state. The tree depth
// sets the query rate. An input word is taken while an earlier result still
// waits in the output register; a result held there keeps the unit in its emit
// state until out_ready, stalling the next word. No clearing pass is needed.
module dynamic_sequence_range_min_unit #(
    parameter int CAPACITY = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  op,
    input  wire logic [10:0] index,
    input  wire logic [10:0] range_end,
    input  wire logic [31:0] value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      min_value,
    output logic             range_nonempty,
    output logic [1:0]       status,
    output logic [10:0]      element_count
);

    localparam int IDX_W = dsrm_pkg::IDX_W;
    localparam int VAL_W = dsrm_pkg::VAL_W;
    localparam int LVL   = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int TMR_W = $clog2(LVL + 1);

    dsrm_pkg::state_t  state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [TMR_W-1:0]  timer_reg, timer_next;
    dsrm_pkg::cmd_t    cmd_reg, dec_cmd, cell_cmd;
    dsrm_pkg::status_t sts_reg, dec_status;

    logic              out_valid_reg;
    logic [VAL_W-1:0]  min_value_reg;
    logic              nonempty_reg;
    logic [1:0]        status_reg;
    logic [IDX_W-1:0]  count_out_reg;

    logic              accept, emit;
    logic [CMP_W-1:0]  index_ext, end_ext, count_ext;
    logic              full;
    logic [IDX_W-1:0]  clip_pos;
    logic [IDX_W-1:0]  clip_end;

    logic [VAL_W-1:0]  cell_val  [CAPACITY];
    dsrm_pkg::key_t    cell_cand [CAPACITY];
    dsrm_pkg::key_t    root;
    logic              root_hit;

    // ---------------------------------------------------------------- decode
    assign index_ext = CMP_W'(index);
    assign end_ext   = CMP_W'(range_end);
    assign count_ext = CMP_W'(count_reg);
    assign full      = (count_ext >= CMP_W'(CAPACITY));
    // clipped values never exceed the 11-bit inputs
    assign clip_pos  = (index_ext > count_ext) ? IDX_W'(count_ext) : index;
    assign clip_end  = (end_ext > count_ext) ? IDX_W'(count_ext) : range_end;

    always_comb
    begin
        dec_cmd.kind    = dsrm_pkg::CMD_NONE;
        dec_cmd.pos     = index;
        dec_cmd.end_pos = clip_end;
        dec_cmd.value   = value;
        dec_status      = dsrm_pkg::STS_DONE;
        count_next      = count_reg;
        unique case (dsrm_pkg::op_t'(op))
            dsrm_pkg::OP_INSERT:
            begin
                if (full)
                    dec_status = dsrm_pkg::STS_FULL;
                else
                begin
                    dec_cmd.kind = dsrm_pkg::CMD_INSERT;
                    dec_cmd.pos  = clip_pos;
                    count_next   = count_reg + CNT_W'(1);
                end
            end
            dsrm_pkg::OP_ERASE:
            begin
                if (index_ext >= count_ext)
                    dec_status = dsrm_pkg::STS_ERASE_PAST;
                else
                begin
                    dec_cmd.kind = dsrm_pkg::CMD_ERASE;
                    count_next   = count_reg - CNT_W'(1);
                end
            end
            dsrm_pkg::OP_SET:
            begin
                if (index_ext < count_ext)
                    dec_cmd.kind = dsrm_pkg::CMD_SET;
                else if (full)
                    dec_status = dsrm_pkg::STS_FULL;
                else
                begin
                    // set past the end appends
                    dec_cmd.kind = dsrm_pkg::CMD_INSERT;
                    dec_cmd.pos  = clip_pos;
                    count_next   = count_reg + CNT_W'(1);
                end
            end
            dsrm_pkg::OP_QUERY:
            begin
                dec_cmd.kind = dsrm_pkg::CMD_QUERY;
            end
            default:
            begin
                dec_cmd.kind = dsrm_pkg::CMD_NONE;
            end
        endcase
    end

    // ----------------------------------------------------------- control FSM
    always_comb
    begin
        state_next = state_reg;
        timer_next = timer_reg;
        unique case (state_reg)
            dsrm_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = dsrm_pkg::ST_EXEC;
            end
            dsrm_pkg::ST_EXEC:
            begin
                if (cmd_reg.kind == dsrm_pkg::CMD_QUERY)
                begin
                    state_next = dsrm_pkg::ST_TREE;
                    timer_next = TMR_W'(LVL - 1);
                end
                else
                    state_next = dsrm_pkg::ST_EMIT;
            end
            dsrm_pkg::ST_TREE:
            begin
                if (timer_reg == '0)
                    state_next = dsrm_pkg::ST_EMIT;
                else
                    timer_next = timer_reg - TMR_W'(1);
            end
            dsrm_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = dsrm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = dsrm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = (state_reg == dsrm_pkg::ST_IDLE);
        emit          = (state_reg == dsrm_pkg::ST_EMIT) && (!out_valid_reg || out_ready);
        cell_cmd      = cmd_reg;
        // row shifts only once, in the execute cycle
        if (state_reg != dsrm_pkg::ST_EXEC)
            cell_cmd.kind = dsrm_pkg::CMD_NONE;
    end

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dsrm_pkg::ST_IDLE;
            count_reg     <= '0;
            timer_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            timer_reg <= timer_next;
            if (accept)
                count_reg <= count_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= dec_cmd;
            sts_reg <= dec_status;
        end
        if (emit)
        begin
            status_reg    <= sts_reg;
            count_out_reg <= IDX_W'(count_reg);
            if (cmd_reg.kind == dsrm_pkg::CMD_QUERY)
            begin
                nonempty_reg  <= root_hit;
                min_value_reg <= root_hit ? (root[VAL_W-1:0] ^ dsrm_pkg::SIGN_BIT)
                                          : dsrm_pkg::EMPTY_MIN;
            end
            else
            begin
                nonempty_reg  <= 1'b0;
                min_value_reg <= '0;
            end
        end
    end

    assign root_hit = !root[VAL_W];

    // -------------------------------------------------------------- cell row
    genvar c;
    generate
        for (c = 0; c < CAPACITY; c++)
        begin : g_cell
            logic [VAL_W-1:0] left_w, right_w;
            if (c == 0)
            begin : g_first
                assign left_w = cell_val[c];
            end
            else
            begin : g_left
                assign left_w = cell_val[c-1];
            end
            if (c == CAPACITY - 1)
            begin : g_last
                assign right_w = cell_val[c];
            end
            else
            begin : g_right
                assign right_w = cell_val[c+1];
            end

            dsrm_cell #(
                .POS_W (CMP_W),
                .POS   (c)
            ) u_cell (
                .clk       (clk),
                .cmd       (cell_cmd),
                .left_val  (left_w),
                .right_val (right_w),
                .val       (cell_val[c]),
                .cand      (cell_cand[c])
            );
        end
    endgenerate

    dsrm_min_tree #(
        .LEAVES (CAPACITY)
    ) u_tree (
        .clk  (clk),
        .leaf (cell_cand),
        .root (root)
    );

    assign out_valid      = out_valid_reg;
    assign min_value      = min_value_reg;
    assign range_nonempty = nonempty_reg;
    assign status         = status_reg;
    assign element_count  = count_out_reg;

    // ------------------------------------------------------------ assertions
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CMP_W'(CAPACITY))
        else $error("element count exceeds capacity");

    a_full_insert_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && full && (op == dsrm_pkg::OP_INSERT)) |=> $stable(count_reg))
        else $error("insert into full store changed the count");

    a_cmd_stable_in_tree: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dsrm_pkg::ST_TREE) |-> $stable(cmd_reg))
        else $error("command changed while the min tree drains");

    a_emit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (out_valid_reg && (state_reg == dsrm_pkg::ST_IDLE)))
        else $error("result not presented after emit");

endmodule

`default_nettype wire
